// File: design/rwad_pkg.sv
// Shared types, constants and the fixed window table of the register window decoder.
package rwad_pkg;

  localparam int unsigned BAR_BYTES = 1048576;
  localparam int unsigned L1_WIN_BYTES = 65536;
  localparam int unsigned WIN_COUNT = 44;
  localparam int unsigned TABLE_ENTRIES = 44;
  localparam int unsigned CHAIN_LEN = (WIN_COUNT < TABLE_ENTRIES) ? WIN_COUNT : TABLE_ENTRIES;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned BAR_BITS = $clog2(BAR_BYTES);
  localparam int unsigned L1_WIN_BITS = $clog2(L1_WIN_BYTES);

  localparam logic [3:0] ACCESS_BYTES = 4'd4;
  localparam logic [32:0] SPACE_TOP = 33'h1_0000_0000;

  localparam logic [31:0] L1_A_LO = 32'h1800_0000;
  localparam logic [31:0] L1_A_HI = 32'h18C0_0000;
  localparam logic [31:0] L1_B_LO = 32'h7000_0000;
  localparam logic [31:0] L1_B_HI = 32'h7800_0000;
  localparam logic [31:0] L1_C_LO = 32'h7C00_0000;
  localparam logic [31:0] L1_C_HI = 32'h7C40_0000;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_WIDTH = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_MISALIGNED = 3'd3;
  localparam logic [2:0] ST_CROSSES = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

  localparam logic [1:0] ROUTE_DIRECT = 2'd0;
  localparam logic [1:0] ROUTE_FIXED = 2'd1;
  localparam logic [1:0] ROUTE_L1 = 2'd2;

  localparam logic CFG_L1_BAR = 1'b0;
  localparam logic CFG_L1_REG = 1'b1;

  localparam logic [31:0] WIN_CHIP [TABLE_ENTRIES] = '{
    32'h0040_0000, 32'h0041_0000, 32'h4000_0000, 32'h5400_0000,
    32'h5500_0000, 32'h5800_0000, 32'h5900_0000, 32'h7403_0000,
    32'h7C00_0000, 32'h7C02_0000, 32'h7C06_0000, 32'h8002_0000,
    32'h8102_0000, 32'h820C_0000, 32'h820C_8000, 32'h820C_C000,
    32'h820C_D000, 32'h820C_E000, 32'h820C_F000, 32'h820D_0000,
    32'h820E_0000, 32'h820E_1000, 32'h820E_2000, 32'h820E_3000,
    32'h820E_4000, 32'h820E_5000, 32'h820E_7000, 32'h820E_9000,
    32'h820E_A000, 32'h820E_B000, 32'h820E_C000, 32'h820E_D000,
    32'h820F_0000, 32'h820F_1000, 32'h820F_2000, 32'h820F_3000,
    32'h820F_4000, 32'h820F_5000, 32'h820F_7000, 32'h820F_9000,
    32'h820F_A000, 32'h820F_B000, 32'h820F_C000, 32'h820F_D000
  };

  localparam logic [19:0] WIN_BAR [TABLE_ENTRIES] = '{
    20'h80000, 20'h90000, 20'h70000, 20'h02000,
    20'h03000, 20'h06000, 20'h07000, 20'h10000,
    20'hF0000, 20'hD0000, 20'hE0000, 20'hB0000,
    20'hC0000, 20'h08000, 20'h0C000, 20'h0E000,
    20'h0F000, 20'h21C00, 20'h22000, 20'h30000,
    20'h20000, 20'h20400, 20'h20800, 20'h20C00,
    20'h21000, 20'h21400, 20'h21E00, 20'h23400,
    20'h24000, 20'h24200, 20'h24600, 20'h24800,
    20'hA0000, 20'hA0600, 20'hA0800, 20'hA0C00,
    20'hA1000, 20'hA1400, 20'hA1E00, 20'hA3400,
    20'hA4000, 20'hA4200, 20'hA4600, 20'hA4800
  };

  localparam logic [16:0] WIN_SIZE [TABLE_ENTRIES] = '{
    17'h10000, 17'h10000, 17'h10000, 17'h01000,
    17'h01000, 17'h01000, 17'h01000, 17'h10000,
    17'h10000, 17'h10000, 17'h10000, 17'h10000,
    17'h10000, 17'h04000, 17'h02000, 17'h01000,
    17'h01000, 17'h00200, 17'h01000, 17'h10000,
    17'h00400, 17'h00200, 17'h00400, 17'h00400,
    17'h00400, 17'h00800, 17'h00200, 17'h00200,
    17'h00200, 17'h00400, 17'h00200, 17'h00800,
    17'h00400, 17'h00200, 17'h00400, 17'h00400,
    17'h00400, 17'h00800, 17'h00200, 17'h00200,
    17'h00200, 17'h00400, 17'h00200, 17'h00800
  };

  typedef struct packed {
    logic [31:0] chip_address;
    logic [3:0]  access_width;
  } rwad_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  route;
    logic [19:0] aperture_offset;
    logic [23:0] remap_register;
    logic [15:0] page_select;
    logic [2:0]  width_out;
  } rwad_out_t;

  typedef struct packed {
    logic        valid;
    logic        done;
    logic [31:0] addr;
    logic [2:0]  status;
    logic [1:0]  route;
    logic [19:0] bar;
  } rwad_stage_t;

endpackage

// File: design/rwad_front.sv
// Entry stage: width, overflow and alignment checks and the direct route.
module rwad_front
  import rwad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  rwad_in_t    word_in,
  output rwad_stage_t stage_out
);

  rwad_stage_t stage_r, stage_nxt;
  logic [32:0] end_addr;

  always_comb begin
    end_addr = {1'b0, word_in.chip_address} + 33'(ACCESS_BYTES);
    stage_nxt = '0;
    stage_nxt.valid = take;
    stage_nxt.addr = word_in.chip_address;
    stage_nxt.route = ROUTE_DIRECT;
    if (word_in.access_width != ACCESS_BYTES) begin
      stage_nxt.done = 1'b1;
      stage_nxt.status = ST_WIDTH;
    end else if (end_addr > SPACE_TOP) begin
      stage_nxt.done = 1'b1;
      stage_nxt.status = ST_OVERFLOW;
    end else if (word_in.chip_address[1:0] != 2'b00) begin
      stage_nxt.done = 1'b1;
      stage_nxt.status = ST_MISALIGNED;
    end else if ({1'b0, word_in.chip_address} < 33'(BAR_BYTES)) begin
      stage_nxt.done = 1'b1;
      stage_nxt.status = (end_addr > 33'(BAR_BYTES)) ? ST_CROSSES : ST_OK;
      stage_nxt.bar = word_in.chip_address[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

// File: design/rwad_cell.sv
// One fixed window cell: match the passing word against its window and hand it on.
module rwad_cell
  import rwad_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] win_idx,
  input  rwad_stage_t      stage_in,
  output rwad_stage_t      stage_out
);

  rwad_stage_t stage_r, stage_nxt;
  logic [31:0] chip;
  logic [32:0] win_end;
  logic [32:0] end_addr;
  logic [19:0] delta;
  logic        hit;

  always_comb begin
    chip = WIN_CHIP[win_idx];
    win_end = {1'b0, chip} + 33'(WIN_SIZE[win_idx]);
    end_addr = {1'b0, stage_in.addr} + 33'(ACCESS_BYTES);
    delta = 20'(stage_in.addr - chip);
    hit = !stage_in.done && (stage_in.addr >= chip) && (end_addr <= win_end);
    stage_nxt = stage_in;
    if (hit) begin
      stage_nxt.done = 1'b1;
      stage_nxt.status = ST_OK;
      stage_nxt.route = ROUTE_FIXED;
      stage_nxt.bar = WIN_BAR[win_idx] + delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

// File: design/rwad_back.sv
// Exit stage: L1 remap ranges, unsupported addresses and the registered result word.
module rwad_back
  import rwad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rwad_stage_t stage_in,
  input  logic [19:0] l1_bar,
  input  logic [23:0] l1_reg,
  output logic        strobe,
  output rwad_out_t   word_out
);

  logic                   strobe_r;
  rwad_out_t              word_r, word_nxt;
  logic [L1_WIN_BITS-1:0] woff;
  logic [32:0]            woff_end;
  logic                   in_l1;
  logic [2:0]             status;
  logic [1:0]             route;
  logic [19:0]            bar;
  logic [23:0]            reg_off;
  logic [15:0]            sel;

  always_comb begin
    woff = stage_in.addr[L1_WIN_BITS-1:0];
    woff_end = 33'(woff) + 33'(ACCESS_BYTES);
    in_l1 = ((stage_in.addr >= L1_A_LO) && (stage_in.addr < L1_A_HI)) ||
            ((stage_in.addr >= L1_B_LO) && (stage_in.addr < L1_B_HI)) ||
            ((stage_in.addr >= L1_C_LO) && (stage_in.addr < L1_C_HI));
    status = stage_in.status;
    route = stage_in.route;
    bar = stage_in.bar;
    reg_off = '0;
    sel = '0;
    if (!stage_in.done) begin
      if (!in_l1) begin
        status = ST_UNSUPPORTED;
      end else if (woff_end > 33'(L1_WIN_BYTES)) begin
        status = ST_CROSSES;
      end else begin
        status = ST_OK;
        route = ROUTE_L1;
        bar = l1_bar + 20'(woff);
        reg_off = l1_reg;
        sel = stage_in.addr[31:16];
      end
    end
    word_nxt = '0;
    word_nxt.status = status;
    if (status == ST_OK) begin
      word_nxt.route = route;
      word_nxt.aperture_offset = bar;
      word_nxt.remap_register = reg_off;
      word_nxt.page_select = sel;
      word_nxt.width_out = ACCESS_BYTES[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign strobe = strobe_r;
  assign word_out = word_r;

endmodule

// File: design/register_window_address_decoder_core.sv
// Top level of the register window address decoder.
//
// Input: a word (chip_address, access_width) is taken at each clock edge where
// start is high and busy is low. busy is low whenever rst_n is high, so a new
// word may be started in every cycle.
// Output: out_strobe marks the result word on out_data for exactly one cycle;
// the receiver cannot hold results off and none is needed.
// Pipeline: one check stage, one cell per fixed window (44 cells, first match wins
// along the row) and one L1 remap and output stage.
// Throughput: one word per cycle; results leave in input order.
// Configuration: cfg_we writes register cfg_index (0: L1 window BAR offset,
// 1: L1 remap register offset) from cfg_wdata in the same edge.
// Reset: synchronous, active low; clears the pipeline valid bits and loads the
// configuration reset values. Words in flight at reset are dropped.
module register_window_address_decoder_core
  import rwad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rwad_in_t    in_data,
  output logic        out_strobe,
  output rwad_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  logic [19:0] l1_bar_r;
  logic [23:0] l1_reg_r;
  rwad_stage_t chain [CHAIN_LEN+1];

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_bar_r <= 20'h40000;
      l1_reg_r <= 24'h155024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_L1_BAR: l1_bar_r <= cfg_wdata[19:0];
        CFG_L1_REG: l1_reg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rwad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .word_in   (in_data),
    .stage_out (chain[0])
  );

  for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
    rwad_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .win_idx   (IDX_W'(g)),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  rwad_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage_in (chain[CHAIN_LEN]),
    .l1_bar   (l1_bar_r),
    .l1_reg   (l1_reg_r),
    .strobe   (out_strobe),
    .word_out (out_data)
  );

endmodule

// File: design/rwad_checker.sv
// Port-level checker for the register window decoder and its bind.
module rwad_checker
  import rwad_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input rwad_out_t out_data
);

  a_no_strobe_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_not_busy: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy raised outside reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != ST_OK) |->
      (out_data.route == ROUTE_DIRECT && out_data.aperture_offset == 20'd0 &&
       out_data.width_out == 3'd0 && out_data.remap_register == 24'd0))
    else $error("failed word carries payload");

  a_ok_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_OK) |-> out_data.width_out == ACCESS_BYTES[2:0])
    else $error("accepted word has wrong width");

  a_remap_only_l1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.route != ROUTE_L1) |->
      (out_data.remap_register == 24'd0 && out_data.page_select == 16'd0))
    else $error("remap fields set off the L1 route");

endmodule

bind register_window_address_decoder_core rwad_checker u_rwad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

// File: dv/tb.sv
// Self-checking testbench for the register window address decoder core.
`timescale 1ns / 1ps

module tb;
  import rwad_pkg::*;

  localparam int unsigned LATENCY = 46;
  localparam int unsigned PHASES = 5;
  localparam int unsigned WORDS_PER_PHASE = 230;
  localparam int unsigned MAX_GAP = 20;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ROWS = 25;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  width;
    logic        typed;
    rwad_out_t   want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [ROWS] = '{
    {32'h0000_0000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_DIRECT, 20'h00000, 24'h000000, 16'h0000, 3'd4}},
    {32'h000F_FFFC, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_DIRECT, 20'hFFFFC, 24'h000000, 16'h0000, 3'd4}},
    {32'h0010_0000, ACCESS_BYTES, 1'b1, {ST_UNSUPPORTED, 65'd0}},
    {32'h0000_0000, 4'h0, 1'b1, {ST_WIDTH, 65'd0}},
    {32'h0000_0000, 4'hF, 1'b1, {ST_WIDTH, 65'd0}},
    {32'h0000_0004, 4'h8, 1'b1, {ST_WIDTH, 65'd0}},
    {32'hFFFF_FFFD, 4'h0, 1'b1, {ST_WIDTH, 65'd0}},
    {32'hFFFF_FFFE, ACCESS_BYTES, 1'b1, {ST_OVERFLOW, 65'd0}},
    {32'hFFFF_FFFF, ACCESS_BYTES, 1'b1, {ST_OVERFLOW, 65'd0}},
    {32'hFFFF_FFFC, ACCESS_BYTES, 1'b1, {ST_UNSUPPORTED, 65'd0}},
    {32'h0000_0001, ACCESS_BYTES, 1'b1, {ST_MISALIGNED, 65'd0}},
    {32'h820C_E002, ACCESS_BYTES, 1'b1, {ST_MISALIGNED, 65'd0}},
    {32'h0040_0000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_FIXED, 20'h80000, 24'h000000, 16'h0000, 3'd4}},
    {32'h820C_E000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_FIXED, 20'h21C00, 24'h000000, 16'h0000, 3'd4}},
    {32'h820C_E1FC, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_FIXED, 20'h21DFC, 24'h000000, 16'h0000, 3'd4}},
    {32'h820C_E200, ACCESS_BYTES, 1'b1, {ST_UNSUPPORTED, 65'd0}},
    {32'h7C00_0000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_FIXED, 20'hF0000, 24'h000000, 16'h0000, 3'd4}},
    {32'h7C01_0000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_L1, 20'h40000, 24'h155024, 16'h7C01, 3'd4}},
    {32'h1800_0000, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_L1, 20'h40000, 24'h155024, 16'h1800, 3'd4}},
    {32'h18BF_FFFC, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_L1, 20'h4FFFC, 24'h155024, 16'h18BF, 3'd4}},
    {32'h18C0_0000, ACCESS_BYTES, 1'b1, {ST_UNSUPPORTED, 65'd0}},
    {32'h77FF_FFFC, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_L1, 20'h4FFFC, 24'h155024, 16'h77FF, 3'd4}},
    {32'h7C3F_FFFC, ACCESS_BYTES, 1'b1,
     {ST_OK, ROUTE_L1, 20'h4FFFC, 24'h155024, 16'h7C3F, 3'd4}},
    {32'h7403_0010, ACCESS_BYTES, 1'b0, 68'd0},
    {32'h820F_D7FC, ACCESS_BYTES, 1'b0, 68'd0}
  };

  localparam int unsigned PHASE_IDLE [PHASES] = '{0, 62, 0, 37, 62};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rwad_in_t    in_data;
  logic        out_strobe;
  rwad_out_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  logic [19:0] l1_bar_cfg;
  logic [23:0] l1_reg_cfg;
  rwad_out_t   plans_due[$];
  int unsigned mismatches;
  int unsigned idle_pct;
  longint unsigned cycles;

  register_window_address_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rwad_out_t decode_address(input rwad_in_t w);
    rwad_out_t   r;
    logic [32:0] last;
    logic [31:0] woff;
    logic        hit;
    int unsigned i;
    r = '0;
    hit = 1'b0;
    last = {1'b0, w.chip_address} + 33'd4;
    woff = w.chip_address & (L1_WIN_BYTES - 1);
    if (w.access_width != ACCESS_BYTES) begin
      r.status = ST_WIDTH;
    end else if (last > SPACE_TOP) begin
      r.status = ST_OVERFLOW;
    end else if (w.chip_address[1:0] != 2'b00) begin
      r.status = ST_MISALIGNED;
    end else if (w.chip_address < BAR_BYTES) begin
      if (last > BAR_BYTES) begin
        r.status = ST_CROSSES;
      end else begin
        r.status = ST_OK;
        r.route = ROUTE_DIRECT;
        r.aperture_offset = w.chip_address[19:0];
      end
    end else begin
      for (i = 0; i < CHAIN_LEN; i++) begin
        if (!hit && w.chip_address >= WIN_CHIP[i] &&
            last <= {1'b0, WIN_CHIP[i]} + WIN_SIZE[i]) begin
          hit = 1'b1;
          r.status = ST_OK;
          r.route = ROUTE_FIXED;
          r.aperture_offset = WIN_BAR[i] + 20'(w.chip_address - WIN_CHIP[i]);
        end
      end
      if (!hit) begin
        if ((w.chip_address >= L1_A_LO && w.chip_address < L1_A_HI) ||
            (w.chip_address >= L1_B_LO && w.chip_address < L1_B_HI) ||
            (w.chip_address >= L1_C_LO && w.chip_address < L1_C_HI)) begin
          if (woff + 4 > L1_WIN_BYTES) begin
            r.status = ST_CROSSES;
          end else begin
            r.status = ST_OK;
            r.route = ROUTE_L1;
            r.aperture_offset = l1_bar_cfg + woff[19:0];
            r.remap_register = l1_reg_cfg;
            r.page_select = w.chip_address[31:16];
          end
        end else begin
          r.status = ST_UNSUPPORTED;
        end
      end
    end
    if (r.status == ST_OK) begin
      r.width_out = 3'(ACCESS_BYTES);
    end
    return r;
  endfunction

  function automatic logic [31:0] l1_bound();
    case ($urandom_range(5))
      0: return L1_A_LO;
      1: return L1_A_HI;
      2: return L1_B_LO;
      3: return L1_B_HI;
      4: return L1_C_LO;
      default: return L1_C_HI;
    endcase
  endfunction

  function automatic rwad_in_t random_word();
    rwad_in_t    w;
    int unsigned pick;
    int unsigned k;
    logic [31:0] lo;
    logic [31:0] hi;
    pick = $urandom_range(99);
    k = $urandom_range(TABLE_ENTRIES - 1);
    w.access_width = ACCESS_BYTES;
    w.chip_address = $urandom;
    if (pick < 35) begin
      w.chip_address = WIN_CHIP[k] + ($urandom_range(WIN_SIZE[k] / 4 - 1) << 2);
    end else if (pick < 55) begin
      case ($urandom_range(2))
        0: begin
          lo = L1_A_LO;
          hi = L1_A_HI;
        end
        1: begin
          lo = L1_B_LO;
          hi = L1_B_HI;
        end
        default: begin
          lo = L1_C_LO;
          hi = L1_C_HI;
        end
      endcase
      w.chip_address = lo + ($urandom_range((hi - lo) / 4 - 1) << 2);
    end else if (pick < 65) begin
      w.chip_address = $urandom_range(BAR_BYTES / 4 - 1) << 2;
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0: w.chip_address = WIN_CHIP[k] + WIN_SIZE[k] - ($urandom_range(1) << 2);
        1: w.chip_address = WIN_CHIP[k] - 4;
        2: w.chip_address = l1_bound() + 4 - ($urandom_range(2) << 2);
        3: w.chip_address = BAR_BYTES + 4 - ($urandom_range(2) << 2);
        default: w.chip_address = 32'hFFFF_FFFC | $urandom_range(3);
      endcase
    end else if (pick >= 85) begin
      w.access_width = $urandom_range(15);
    end
    return w;
  endfunction

  task automatic send_word(input rwad_in_t w, input logic typed, input rwad_out_t want);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    plans_due.push_back(typed ? want : decode_address(w));
  endtask

  task automatic drain();
    while (plans_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_windows(input logic [23:0] bar_word, input logic [23:0] reg_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_L1_BAR;
    cfg_wdata <= bar_word;
    @(posedge clk);
    cfg_index <= CFG_L1_REG;
    cfg_wdata <= reg_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    l1_bar_cfg = bar_word[19:0];
    l1_reg_cfg = reg_word;
  endtask

  task automatic match_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rwad_out_t want;
    if (rst_n && out_strobe) begin
      if (plans_due.size() == 0) begin
        $error("result word with nothing pending: 0x%0h", out_data);
        mismatches++;
      end else begin
        want = plans_due.pop_front();
        match_field("status", want.status, out_data.status);
        match_field("route", want.route, out_data.route);
        match_field("aperture_offset", want.aperture_offset, out_data.aperture_offset);
        match_field("remap_register", want.remap_register, out_data.remap_register);
        match_field("page_select", want.page_select, out_data.page_select);
        match_field("width_out", want.width_out, out_data.width_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("register_window_address_decoder_core test failed");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    cycles = 0;
    mismatches = 0;
    idle_pct = 0;
    l1_bar_cfg = 20'h40000;
    l1_reg_cfg = 24'h155024;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_L1_BAR;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        1: set_windows(24'hFFFFFF, 24'hFFFFFF);
        2: set_windows(24'h000000, 24'h000000);
        3: set_windows(24'($urandom), 24'($urandom));
        4: set_windows({4'h0, 4'hF, 16'($urandom)}, 24'($urandom));
        default: ;
      endcase
      idle_pct = PHASE_IDLE[ph];
      if (ph == 0) begin
        for (n = 0; n < ROWS; n++) begin
          send_word({DIRECTED_ROWS[n].addr, DIRECTED_ROWS[n].width},
                    DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
        end
      end
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(random_word(), 1'b0, '0);
      end
      start <= 1'b0;
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("register_window_address_decoder_core test passed");
    end else begin
      $display("register_window_address_decoder_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/rwad_pkg.sv
design/rwad_front.sv
design/rwad_cell.sv
design/rwad_back.sv
design/register_window_address_decoder_core.sv
design/rwad_checker.sv
dv/tb.sv
